// File: src/nlf_pkg.sv
`default_nettype none

package nlf_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int MAX_W          = 7;
    localparam int BYTE_W         = 8;
    localparam int CNT_W          = 32;
    localparam int KIND_W         = 2;

    localparam logic [MAX_W-1:0]  MAX_LINE_RST = 7'd64;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE = 2'd0,
        KIND_LONG = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DATA
    } t_state;

endpackage

`default_nettype wire

// File: src/nlf_ram.sv
`default_nettype none

module nlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/nmea_line_framer.sv
// Channel   Dir  Handshake            Payload
// s_*       in   tvalid/tready        tdata: rx_byte
// m_*       out  tvalid/tready        tdata: line_byte, sentence_total, error_total;
//                                     tuser: kind; tlast: last_of_line
// cfg_*     in   valid/ready          data: max_line_out
//
// A sentence drains from the line RAM after its LF beat, one byte at a time:
// a read of the RAM (S_READ), then a load of the output register (S_DATA),
// which waits while the output is stalled.
// Reset is synchronous, active low; it clears the counters and the fill count
// and sets max_line_out to 64. The line RAM is not cleared.
// Input is held off while a sentence drains and while a result is stalled.
`default_nettype none

module nmea_line_framer #(
    parameter int LINE_BYTES = nlf_pkg::LINE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // [7:0] line_byte, [39:8] sentence_total,
                                          // [71:40] error_total
    output logic             o_m_tlast,
    output logic [1:0]       o_m_tuser,   // [1:0] kind
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int BW = nlf_pkg::BYTE_W;
    localparam int CW = nlf_pkg::CNT_W;
    localparam int MW = nlf_pkg::MAX_W;

    nlf_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_fill, n_fill;
    logic            r_last_cr, n_last_cr;
    logic            r_first_ok, n_first_ok;
    logic [MW-1:0]   r_max;
    logic [CW-1:0]   r_sent_cnt, n_sent_cnt;
    logic [CW-1:0]   r_err_cnt, n_err_cnt;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_n, n_n;
    logic            r_zeroed, n_zeroed;

    logic            r_out_valid, n_out_valid;
    nlf_pkg::t_kind  r_out_kind, n_out_kind;
    logic [BW-1:0]   r_out_byte, n_out_byte;
    logic            r_out_last, n_out_last;
    logic [CW-1:0]   r_out_sent, n_out_sent;
    logic [CW-1:0]   r_out_err, n_out_err;

    logic            s_acc;
    logic            is_start;
    logic            is_term;
    logic            full;
    logic            out_free;
    logic [AW-1:0]   len;
    logic [MW-1:0]   room;
    logic [AW-1:0]   n_calc;
    logic [AW-1:0]   idx_inc;
    logic            z_now;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;
    logic [BW-1:0]   rd_data;

    nlf_ram #(
        .WIDTH (BW),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == nlf_pkg::S_IDLE) && (!r_out_valid || i_m_tready);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;

    assign is_start = (i_s_tdata == nlf_pkg::CH_DOLLAR) || (i_s_tdata == nlf_pkg::CH_BANG);
    assign is_term  = (i_s_tdata == nlf_pkg::CH_LF) || (i_s_tdata == nlf_pkg::CH_CR);
    assign full     = r_fill >= AW'(LINE_BYTES - 1);

    assign wr_en    = s_acc && (is_start || !full);
    assign wr_addr  = is_start ? '0 : r_fill;
    assign rd_en    = (r_state == nlf_pkg::S_READ);

    // drop a trailing CR along with the LF
    assign len    = r_last_cr ? (r_fill - AW'(1)) : r_fill;
    assign room   = (r_max == '0) ? '0 : (r_max - MW'(1));
    assign n_calc = ({{(MW-AW){1'b0}}, len} < room) ? len : AW'(room);

    assign idx_inc = r_idx + AW'(1);
    assign z_now   = r_zeroed || (rd_data == '0);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_last_cr   = r_last_cr;
        n_first_ok  = r_first_ok;
        n_sent_cnt  = r_sent_cnt;
        n_err_cnt   = r_err_cnt;
        n_idx       = r_idx;
        n_n         = r_n;
        n_zeroed    = r_zeroed;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_sent  = r_out_sent;
        n_out_err   = r_out_err;

        case (r_state)
            nlf_pkg::S_IDLE: begin
                if (s_acc) begin
                    if (is_start) begin
                        n_fill     = AW'(1);
                        n_last_cr  = 1'b0;
                        n_first_ok = 1'b1;
                    end else if (full) begin
                        if (is_term) begin
                            n_fill      = '0;
                            n_last_cr   = 1'b0;
                            n_err_cnt   = r_err_cnt + CW'(1);
                            n_out_valid = 1'b1;
                            n_out_kind  = nlf_pkg::KIND_LONG;
                            n_out_byte  = '0;
                            n_out_last  = 1'b1;
                            n_out_sent  = r_sent_cnt;
                            n_out_err   = r_err_cnt + CW'(1);
                        end
                    end else begin
                        n_fill    = r_fill + AW'(1);
                        n_last_cr = (i_s_tdata == nlf_pkg::CH_CR);
                        if (r_fill == '0) begin
                            n_first_ok = 1'b0;
                        end
                        if (i_s_tdata == nlf_pkg::CH_LF) begin
                            n_fill    = '0;
                            n_last_cr = 1'b0;
                            if (n_calc == '0 || !r_first_ok) begin
                                n_err_cnt   = r_err_cnt + CW'(1);
                                n_out_valid = 1'b1;
                                n_out_kind  = nlf_pkg::KIND_BAD;
                                n_out_byte  = '0;
                                n_out_last  = 1'b1;
                                n_out_sent  = r_sent_cnt;
                                n_out_err   = r_err_cnt + CW'(1);
                            end else begin
                                n_sent_cnt = r_sent_cnt + CW'(1);
                                n_idx      = '0;
                                n_n        = n_calc;
                                n_zeroed   = 1'b0;
                                n_state    = nlf_pkg::S_READ;
                            end
                        end
                    end
                end
            end
            nlf_pkg::S_READ: begin
                n_state = nlf_pkg::S_DATA;
            end
            nlf_pkg::S_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = nlf_pkg::KIND_BYTE;
                    n_out_byte  = z_now ? '0 : rd_data;
                    n_out_last  = (idx_inc == r_n);
                    n_out_sent  = r_sent_cnt;
                    n_out_err   = r_err_cnt;
                    n_zeroed    = z_now;
                    n_idx       = idx_inc;
                    n_state     = (idx_inc == r_n) ? nlf_pkg::S_IDLE : nlf_pkg::S_READ;
                end
            end
            default: begin
                n_state = nlf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nlf_pkg::S_IDLE;
            r_fill      <= '0;
            r_last_cr   <= 1'b0;
            r_first_ok  <= 1'b0;
            r_max       <= nlf_pkg::MAX_LINE_RST;
            r_sent_cnt  <= '0;
            r_err_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_last_cr   <= n_last_cr;
            r_first_ok  <= n_first_ok;
            r_sent_cnt  <= n_sent_cnt;
            r_err_cnt   <= n_err_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_zeroed   <= n_zeroed;
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_sent <= n_out_sent;
        r_out_err  <= n_out_err;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_err, r_out_sent, r_out_byte};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_kind;

`ifndef SYNTHESIS
    a_drop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != nlf_pkg::KIND_BYTE) |-> r_out_last)
        else $error("drop result without last mark");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= AW'(LINE_BYTES - 1))
        else $error("fill count beyond line store");

    a_err_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_err_cnt != $past(r_err_cnt))
            |-> (r_err_cnt == $past(r_err_cnt) + CW'(1)))
        else $error("error count moved by more than one");

    a_drain_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != nlf_pkg::S_IDLE) |-> (r_fill == '0))
        else $error("line fill not cleared while draining");
`endif

endmodule

`default_nettype wire
